// File: rtl/ccw_pkg.sv
// shared types and constants for the circuit credit window table
`default_nettype none

package ccw_pkg;

  // widths fixed by the interface
  localparam int unsigned WIN_W  = 16;
  localparam int unsigned CIRC_W = 4;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // event kinds carried in the request type field
  typedef enum logic [1:0] {
    EV_OPEN    = 2'd0,
    EV_PACKAGE = 2'd1,
    EV_SENDME  = 2'd2,
    EV_DELIVER = 2'd3
  } ev_kind_t;

  // register index taken from the word address
  typedef enum logic {
    REG_START = 1'b0,
    REG_INCR  = 1'b1
  } reg_idx_t;

  // reset values of the configuration registers
  localparam logic [WIN_W-1:0] START_RESET = 16'd1000;
  localparam logic [WIN_W-1:0] INCR_RESET  = 16'd100;

  // one circuit's window state
  typedef struct packed {
    logic [WIN_W-1:0] pkg_win;
    logic [WIN_W-1:0] dlv_win;
    logic             blocked;
  } circ_entry_t;

  // flags produced by one event
  typedef struct packed {
    logic send_sendme;
    logic resume_read;
  } ev_flags_t;

endpackage

`default_nettype wire

// File: rtl/ccw_table.sv
// per-circuit window state table, one read and one write port
`default_nettype none

module ccw_table #(
  parameter int unsigned NUM_CIRCUITS = 16,
  parameter int unsigned IDX_W        = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [IDX_W-1:0]    rd_idx,
  output ccw_pkg::circ_entry_t     rd_entry,
  input  wire logic                wr_en,
  input  wire logic [IDX_W-1:0]    wr_idx,
  input  wire ccw_pkg::circ_entry_t wr_entry
);

  ccw_pkg::circ_entry_t entry_r [NUM_CIRCUITS];

  // state update, cleared on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(NUM_CIRCUITS); i++) begin
        entry_r[i] <= '0;
      end
    end else if (wr_en) begin
      entry_r[wr_idx] <= wr_entry;
    end
  end

  // read port
  assign rd_entry = entry_r[rd_idx];

endmodule

`default_nettype wire

// File: rtl/ccw_calc.sv
// next-state and result logic for one credit window event
`default_nettype none

module ccw_calc (
  input  wire ccw_pkg::ev_kind_t            kind,
  input  wire ccw_pkg::circ_entry_t         cur,
  input  wire logic [ccw_pkg::WIN_W-1:0]    win_start,
  input  wire logic [ccw_pkg::WIN_W-1:0]    win_incr,
  output ccw_pkg::circ_entry_t              nxt,
  output ccw_pkg::ev_flags_t                flags
);

  logic [ccw_pkg::WIN_W-1:0] pkg_dec;
  logic [ccw_pkg::WIN_W-1:0] dlv_dec;
  logic [ccw_pkg::WIN_W-1:0] incr_eff;
  logic [ccw_pkg::WIN_W-1:0] thresh;
  logic [ccw_pkg::WIN_W:0]   pkg_sum;
  logic [ccw_pkg::WIN_W:0]   dlv_sum;
  logic [ccw_pkg::WIN_W-1:0] pkg_cap;
  logic [ccw_pkg::WIN_W-1:0] dlv_cap;

  // saturating decrements
  assign pkg_dec = (cur.pkg_win != '0) ? cur.pkg_win - 1'b1 : '0;
  assign dlv_dec = (cur.dlv_win != '0) ? cur.dlv_win - 1'b1 : '0;

  // refill threshold, increment clamped to start
  assign incr_eff = (win_incr > win_start) ? win_start : win_incr;
  assign thresh   = win_start - incr_eff;

  // credit added and capped at start
  assign pkg_sum = {1'b0, cur.pkg_win} + {1'b0, win_incr};
  assign dlv_sum = {1'b0, dlv_dec} + {1'b0, win_incr};
  assign pkg_cap = (pkg_sum > {1'b0, win_start}) ? win_start : pkg_sum[ccw_pkg::WIN_W-1:0];
  assign dlv_cap = (dlv_sum > {1'b0, win_start}) ? win_start : dlv_sum[ccw_pkg::WIN_W-1:0];

  // per-kind update
  always_comb begin
    nxt   = cur;
    flags = '0;
    unique case (kind)
      ccw_pkg::EV_OPEN: begin
        nxt.pkg_win = win_start;
        nxt.dlv_win = win_start;
        nxt.blocked = 1'b0;
      end
      ccw_pkg::EV_PACKAGE: begin
        nxt.pkg_win = pkg_dec;
        if (pkg_dec == '0) begin
          nxt.blocked = 1'b1;
        end
      end
      ccw_pkg::EV_SENDME: begin
        nxt.pkg_win       = pkg_cap;
        nxt.blocked       = 1'b0;
        flags.resume_read = cur.blocked;
      end
      ccw_pkg::EV_DELIVER: begin
        if (dlv_dec <= thresh) begin
          nxt.dlv_win       = dlv_cap;
          flags.send_sendme = 1'b1;
        end else begin
          nxt.dlv_win = dlv_dec;
        end
      end
      default: begin
        nxt   = cur;
        flags = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/circuit_credit_window_table.sv
// top level: per-circuit end-to-end credit window table
// throughput: one word per cycle unless the result side stalls
// a word goes through the input register, then the table is read, updated and
//   written back in the single compute stage before the result register
// reset: synchronous active-low rst_n clears all windows and block flags,
//   loads window start 1000 and increment 100, and empties both stages
`default_nettype none

module circuit_credit_window_table #(
  parameter int unsigned NUM_CIRCUITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic [ccw_pkg::CIRC_W-1:0]    in_circuit_index,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ccw_pkg::WIN_W-1:0]          out_package_level,
  output logic [ccw_pkg::WIN_W-1:0]          out_deliver_level,
  output logic                               out_read_blocked,
  output logic                               out_send_sendme,
  output logic                               out_resume_read,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ccw_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [ccw_pkg::DATA_W-1:0]    pwdata,
  output logic [ccw_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam int unsigned IDX_W = (NUM_CIRCUITS > 1) ? $clog2(NUM_CIRCUITS) : 1;

  logic [ccw_pkg::WIN_W-1:0]  start_r;
  logic [ccw_pkg::WIN_W-1:0]  incr_r;
  ccw_pkg::reg_idx_t          reg_sel;

  logic                       in_vld_r;
  ccw_pkg::ev_kind_t          kind_r;
  logic [ccw_pkg::CIRC_W-1:0] circ_r;

  logic                       advance;
  logic                       in_range;
  logic [IDX_W-1:0]           tbl_idx;
  ccw_pkg::circ_entry_t       cur_entry;
  ccw_pkg::circ_entry_t       nxt_entry;
  ccw_pkg::ev_flags_t         ev_flags;

  logic                       out_vld_r;
  logic [ccw_pkg::WIN_W-1:0]  pkg_lvl_r;
  logic [ccw_pkg::WIN_W-1:0]  dlv_lvl_r;
  logic                       blk_r;
  logic                       sendme_r;
  logic                       resume_r;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = ccw_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= ccw_pkg::START_RESET;
      incr_r  <= ccw_pkg::INCR_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        ccw_pkg::REG_START: start_r <= pwdata[ccw_pkg::WIN_W-1:0];
        ccw_pkg::REG_INCR:  incr_r  <= pwdata[ccw_pkg::WIN_W-1:0];
        default:            start_r <= start_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      ccw_pkg::REG_START: prdata = {{(ccw_pkg::DATA_W-ccw_pkg::WIN_W){1'b0}}, start_r};
      ccw_pkg::REG_INCR:  prdata = {{(ccw_pkg::DATA_W-ccw_pkg::WIN_W){1'b0}}, incr_r};
      default:            prdata = '0;
    endcase
  end

  // stage handshake
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= ccw_pkg::ev_kind_t'(in_req_type);
      circ_r <= in_circuit_index;
    end
  end

  // table lookup
  assign in_range = {{(32-ccw_pkg::CIRC_W){1'b0}}, circ_r} < NUM_CIRCUITS;
  assign tbl_idx  = IDX_W'(circ_r);

  ccw_table #(
    .NUM_CIRCUITS (NUM_CIRCUITS),
    .IDX_W        (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (tbl_idx),
    .rd_entry (cur_entry),
    .wr_en    (advance && in_range),
    .wr_idx   (tbl_idx),
    .wr_entry (nxt_entry)
  );

  ccw_calc u_calc (
    .kind      (kind_r),
    .cur       (cur_entry),
    .win_start (start_r),
    .win_incr  (incr_r),
    .nxt       (nxt_entry),
    .flags     (ev_flags)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_range) begin
        pkg_lvl_r <= nxt_entry.pkg_win;
        dlv_lvl_r <= nxt_entry.dlv_win;
        blk_r     <= nxt_entry.blocked;
        sendme_r  <= ev_flags.send_sendme;
        resume_r  <= ev_flags.resume_read;
      end else begin
        pkg_lvl_r <= '0;
        dlv_lvl_r <= '0;
        blk_r     <= 1'b0;
        sendme_r  <= 1'b0;
        resume_r  <= 1'b0;
      end
    end
  end

  assign out_valid         = out_vld_r;
  assign out_package_level = pkg_lvl_r;
  assign out_deliver_level = dlv_lvl_r;
  assign out_read_blocked  = blk_r;
  assign out_send_sendme   = sendme_r;
  assign out_resume_read   = resume_r;

endmodule

`default_nettype wire

// File: rtl/ccw_checker.sv
// port-level checks for the credit window table, bound to the top level
`default_nettype none

module ccw_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [ccw_pkg::WIN_W-1:0]  out_package_level,
  input wire logic [ccw_pkg::WIN_W-1:0]  out_deliver_level,
  input wire logic                       out_read_blocked,
  input wire logic                       out_send_sendme,
  input wire logic                       out_resume_read
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_package_level)
      && $stable(out_deliver_level) && $stable(out_read_blocked)
      && $stable(out_send_sendme) && $stable(out_resume_read))
    else $error("stalled result word changed");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // sendme request and resume come from different event kinds
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_send_sendme && out_resume_read))
    else $error("sendme and resume flagged together");

  // a lifted block leaves the circuit unblocked
  a_resume_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resume_read |-> !out_read_blocked)
    else $error("resume reported while still blocked");

endmodule

bind circuit_credit_window_table ccw_checker u_ccw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_package_level (out_package_level),
  .out_deliver_level (out_deliver_level),
  .out_read_blocked  (out_read_blocked),
  .out_send_sendme   (out_send_sendme),
  .out_resume_read   (out_resume_read)
);

`default_nettype wire

// File: verif/credit_window_checker.sv
// checker for the circuit credit window table: mirrors the window state and compares each word
`timescale 1ns / 100ps

module credit_window_checker #(
  parameter int unsigned NUM_CIRCUITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 in_req_type,
  input  logic [ccw_pkg::CIRC_W-1:0] in_circuit_index,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [ccw_pkg::WIN_W-1:0]  out_package_level,
  input  logic [ccw_pkg::WIN_W-1:0]  out_deliver_level,
  input  logic                       out_read_blocked,
  input  logic                       out_send_sendme,
  input  logic                       out_resume_read,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccw_pkg::ADDR_W-1:0] paddr,
  input  logic [ccw_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  output int                         mismatch_count = 0,
  output int                         results_seen = 0
);

  // one result word as the block reports it
  typedef struct packed {
    logic [ccw_pkg::WIN_W-1:0] package_level;
    logic [ccw_pkg::WIN_W-1:0] deliver_level;
    logic                      read_blocked;
    logic                      send_sendme;
    logic                      resume_read;
  } window_report_t;

  window_report_t   pending_reports[$];

  // mirrored configuration and per-circuit windows
  logic [ccw_pkg::WIN_W-1:0] window_start;
  logic [ccw_pkg::WIN_W-1:0] window_incr;
  logic [ccw_pkg::WIN_W-1:0] pkg_win [NUM_CIRCUITS];
  logic [ccw_pkg::WIN_W-1:0] dlv_win [NUM_CIRCUITS];
  logic                      blocked [NUM_CIRCUITS];

  // level plus one increment, never above window start
  function automatic logic [ccw_pkg::WIN_W-1:0] add_credit(
      input logic [ccw_pkg::WIN_W-1:0] level);
    logic [ccw_pkg::WIN_W:0] sum;
    sum = {1'b0, level} + {1'b0, window_incr};
    if (sum > {1'b0, window_start})
      sum = {1'b0, window_start};
    return sum[ccw_pkg::WIN_W-1:0];
  endfunction

  // update the mirrored circuit and return the word the block should send
  function automatic window_report_t apply_cell_event(
      input ccw_pkg::ev_kind_t kind, input logic [ccw_pkg::CIRC_W-1:0] circ);
    window_report_t            rep;
    logic [ccw_pkg::WIN_W-1:0] step;
    logic [ccw_pkg::WIN_W-1:0] refill_level;
    int unsigned               idx;
    rep = '0;
    idx = circ;
    // circuits beyond the table are ignored and report all zero
    if (idx >= NUM_CIRCUITS)
      return rep;
    case (kind)
      ccw_pkg::EV_OPEN: begin
        pkg_win[idx] = window_start;
        dlv_win[idx] = window_start;
        blocked[idx] = 1'b0;
      end
      ccw_pkg::EV_PACKAGE: begin
        if (pkg_win[idx] != '0)
          pkg_win[idx] = pkg_win[idx] - 1'b1;
        if (pkg_win[idx] == '0)
          blocked[idx] = 1'b1;
      end
      ccw_pkg::EV_SENDME: begin
        pkg_win[idx] = add_credit(pkg_win[idx]);
        if (blocked[idx]) begin
          blocked[idx]    = 1'b0;
          rep.resume_read = 1'b1;
        end
      end
      ccw_pkg::EV_DELIVER: begin
        // increment clipped to start so the refill level never wraps
        step         = (window_incr > window_start) ? window_start : window_incr;
        refill_level = window_start - step;
        if (dlv_win[idx] != '0)
          dlv_win[idx] = dlv_win[idx] - 1'b1;
        if (dlv_win[idx] <= refill_level) begin
          dlv_win[idx]    = add_credit(dlv_win[idx]);
          rep.send_sendme = 1'b1;
        end
      end
    endcase
    rep.package_level = pkg_win[idx];
    rep.deliver_level = dlv_win[idx];
    rep.read_blocked  = blocked[idx];
    return rep;
  endfunction

  task automatic flag_mismatch(input string why, input window_report_t want,
                               input window_report_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected pkg=%0d dlv=%0d blk=%0b sendme=%0b resume=%0b,",
               $time, why, want.package_level, want.deliver_level, want.read_blocked,
               want.send_sendme, want.resume_read,
               " got pkg=%0d dlv=%0d blk=%0b sendme=%0b resume=%0b",
               got.package_level, got.deliver_level, got.read_blocked,
               got.send_sendme, got.resume_read);
  endtask

  always @(posedge clk) begin
    window_report_t got;
    window_report_t want;
    if (!rst_n) begin
      window_start = ccw_pkg::START_RESET;
      window_incr  = ccw_pkg::INCR_RESET;
      for (int i = 0; i < NUM_CIRCUITS; i++) begin
        pkg_win[i] = '0;
        dlv_win[i] = '0;
        blocked[i] = 1'b0;
      end
      pending_reports.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (ccw_pkg::reg_idx_t'(paddr[ccw_pkg::ADDR_W-1:2]))
          ccw_pkg::REG_START: window_start = pwdata[ccw_pkg::WIN_W-1:0];
          ccw_pkg::REG_INCR:  window_incr  = pwdata[ccw_pkg::WIN_W-1:0];
        endcase
      end
      // compare each accepted result word with the oldest pending one
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        got = {out_package_level, out_deliver_level, out_read_blocked,
               out_send_sendme, out_resume_read};
        if (pending_reports.size() == 0) begin
          flag_mismatch("result word with nothing pending", '0, got);
        end else begin
          want = pending_reports.pop_front();
          if (got !== want)
            flag_mismatch("result word mismatch", want, got);
        end
      end
      // predict the result of each accepted event word, queued at the tail
      if (in_valid && in_ready)
        pending_reports.insert(pending_reports.size(),
                               apply_cell_event(ccw_pkg::ev_kind_t'(in_req_type),
                                                in_circuit_index));
    end
  end

endmodule

// File: verif/tb_circuit_credit_window_table.sv
// testbench top for the circuit credit window table: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_circuit_credit_window_table;

  localparam int unsigned CYCLE_LIMIT = 500000;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 in_req_type = '0;
  logic [ccw_pkg::CIRC_W-1:0] in_circuit_index = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [ccw_pkg::WIN_W-1:0]  out_package_level;
  logic [ccw_pkg::WIN_W-1:0]  out_deliver_level;
  logic                       out_read_blocked;
  logic                       out_send_sendme;
  logic                       out_resume_read;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ccw_pkg::ADDR_W-1:0] paddr = '0;
  logic [ccw_pkg::DATA_W-1:0] pwdata = '0;
  logic [ccw_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  int                mismatch_count;
  int                results_seen;
  int                words_sent = 0;
  int                idle_pct = 0;
  int                stall_left = 0;
  int unsigned       cycle_count = 0;

  circuit_credit_window_table uut (.*);

  credit_window_checker window_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side stalls in random bursts when idling is enabled
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // present one event word, maybe after a gap, and wait until it is taken
  task automatic send_word(input ccw_pkg::ev_kind_t kind,
                           input logic [ccw_pkg::CIRC_W-1:0] circ);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= kind;
    in_circuit_index <= circ;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // stop sending and let every pending word come out
  task automatic drain();
    in_valid <= 1'b0;
    while (results_seen < words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write with junk in the unused upper bits, bus left selected
  task automatic write_reg(input ccw_pkg::reg_idx_t idx,
                           input logic [ccw_pkg::WIN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_windows(input logic [ccw_pkg::WIN_W-1:0] start,
                             input logic [ccw_pkg::WIN_W-1:0] incr);
    drain();
    write_reg(ccw_pkg::REG_START, start);
    write_reg(ccw_pkg::REG_INCR, incr);
    // release the bus after the last access
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // random traffic focused on a few circuits so windows run down
  task automatic random_words(input int count, input int idle);
    int                roll;
    ccw_pkg::ev_kind_t kind;
    idle_pct = idle;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 6)
        kind = ccw_pkg::EV_OPEN;
      else if (roll < 46)
        kind = ccw_pkg::EV_PACKAGE;
      else if (roll < 66)
        kind = ccw_pkg::EV_SENDME;
      else
        kind = ccw_pkg::EV_DELIVER;
      if ($urandom_range(0, 9) < 7)
        send_word(kind, ccw_pkg::CIRC_W'($urandom_range(0, 3)));
      else
        send_word(kind, ccw_pkg::CIRC_W'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset windows
    send_word(ccw_pkg::EV_PACKAGE, 4'd5);   // never opened, package at zero blocks
    send_word(ccw_pkg::EV_PACKAGE, 4'd5);
    send_word(ccw_pkg::EV_SENDME, 4'd5);    // lifts the block
    send_word(ccw_pkg::EV_DELIVER, 4'd6);   // delivery at zero refills and asks for a sendme
    send_word(ccw_pkg::EV_SENDME, 4'd9);    // unblocked circuit, no resume
    send_word(ccw_pkg::EV_OPEN, 4'd0);
    send_word(ccw_pkg::EV_PACKAGE, 4'd0);
    send_word(ccw_pkg::EV_SENDME, 4'd0);    // capped at start
    send_word(ccw_pkg::EV_DELIVER, 4'd0);
    send_word(ccw_pkg::EV_OPEN, 4'd15);
    send_word(ccw_pkg::EV_DELIVER, 4'd15);
    send_word(ccw_pkg::EV_PACKAGE, 4'd15);
    send_word(ccw_pkg::EV_SENDME, 4'd15);
    send_word(ccw_pkg::EV_PACKAGE, 4'd7);   // blocks
    send_word(ccw_pkg::EV_OPEN, 4'd7);      // open clears the block without resume
    send_word(ccw_pkg::EV_SENDME, 4'd7);
    send_word(ccw_pkg::EV_DELIVER, 4'd10);
    send_word(ccw_pkg::EV_OPEN, 4'd10);
    send_word(ccw_pkg::EV_DELIVER, 4'd10);

    random_words(150, 20);
    // smallest windows
    set_windows(16'd1, 16'd1);
    random_words(300, 30);
    // largest windows, opens leave circuits far above later starts
    set_windows(16'hFFFF, 16'hFFFF);
    random_words(200, 10);
    // increment above start, windows above start
    set_windows(16'd5, 16'hFFFF);
    random_words(300, 0);
    set_windows(16'd12, 16'd4);
    random_words(400, 15);
    set_windows(16'hFFFF, 16'd1);
    random_words(200, 25);
    // last stretch without idling
    set_windows(16'd9, 16'd3);
    random_words(380, 0);

    drain();
    if (mismatch_count == 0 && results_seen == words_sent)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
